// File: sv/mmdsa_pkg.sv
// Shared types and constants for the max-min distance slot allocator.
// No dependencies; imported by every module of the block.
package mmdsa_pkg;

	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] NUM_CHAIRS_RST = 7'd64;

	localparam logic ACT_ARRIVE = 1'b0;
	localparam logic ACT_LEAVE  = 1'b1;

	// per-cell controls of the occupancy ring
	typedef struct packed {
		logic shift;  // rotate one place toward cell 0
		logic wr;     // load val (wins over shift, never both)
		logic val;
	} cell_ctrl_t;

	// gap scanner controls
	typedef struct packed {
		logic start;  // clear scan state, position back to slot 1
		logic step;   // consume the head occupancy bit
	} scan_ctrl_t;

endpackage

// File: sv/mmdsa_cell.sv
// One occupancy cell of the slot ring: holds the busy bit of one slot.
// Depends on mmdsa_pkg (cell_ctrl_t).
module mmdsa_cell
	import mmdsa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       shift_in,
	output logic       occ
);

	logic occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.wr) begin
			occ_q <= ctrl.val;
		end else if (ctrl.shift) begin
			occ_q <= shift_in;
		end
	end

	assign occ = occ_q;

endmodule

// File: sv/mmdsa_scan.sv
// Gap scanner: walks the occupancy bits in slot order, one per beat of the ring,
// and keeps the best candidate slot seen so far. Depends on mmdsa_pkg (scan_ctrl_t).
module mmdsa_scan
	import mmdsa_pkg::*;
#(
	parameter int MAX_CHAIRS = 64
)
(
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  scan_ctrl_t                           ctrl,
	input  logic                                 head,
	input  logic [$clog2(MAX_CHAIRS+1)-1:0]      n_eff,
	output logic                                 last_step,
	output logic                                 pick_ok,
	output logic [$clog2(MAX_CHAIRS+1)-1:0]      pick_slot
);

	localparam int CW = $clog2(MAX_CHAIRS + 1);

	logic [CW-1:0] pos_q;
	logic [CW-1:0] last_q;
	logic [CW-1:0] best_s_q;
	logic [CW-1:0] best_d_q;
	logic          found_q;

	logic [CW-1:0] gap;
	logic [CW-1:0] half;
	logic [CW-1:0] mid;
	logic          c_ok;
	logic [CW-1:0] c_s;
	logic [CW-1:0] c_d;
	logic          take;
	logic          e_ok;
	logic [CW-1:0] e_d;

	// candidate of the gap that closes at the current slot, if it is occupied
	always_comb begin
		gap  = pos_q - last_q;
		half = gap >> 1;
		mid  = last_q + half;
		if (last_q == '0) begin
			// leading gap: slot 1 is farthest from the first busy slot
			c_ok = pos_q >= CW'(2);
			c_s  = CW'(1);
			c_d  = pos_q - CW'(1);
		end else begin
			c_ok = (gap >= CW'(2)) && (last_q < n_eff);
			if (mid <= n_eff) begin
				c_s = mid;
				c_d = half;
			end else begin
				c_s = n_eff;
				c_d = n_eff - last_q;
			end
		end
		take = head && c_ok && (!found_q || (c_d > best_d_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= CW'(1);
			last_q  <= '0;
			found_q <= 1'b0;
		end else if (ctrl.start) begin
			pos_q   <= CW'(1);
			last_q  <= '0;
			found_q <= 1'b0;
		end else if (ctrl.step) begin
			pos_q <= pos_q + CW'(1);
			if (head) begin
				last_q <= pos_q;
			end
			if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step && take) begin
			best_s_q <= c_s;
			best_d_q <= c_d;
		end
	end

	assign last_step = (pos_q == CW'(MAX_CHAIRS));

	// trailing gap: highest active slot, no right neighbor
	always_comb begin
		e_ok = (last_q != '0) && (n_eff > last_q);
		e_d  = n_eff - last_q;
		if (last_q == '0) begin
			// nothing busy anywhere
			pick_ok   = 1'b1;
			pick_slot = CW'(1);
		end else if (e_ok && (!found_q || (e_d > best_d_q))) begin
			pick_ok   = 1'b1;
			pick_slot = n_eff;
		end else begin
			pick_ok   = found_q;
			pick_slot = best_s_q;
		end
	end

endmodule

// File: sv/max_min_distance_slot_allocator.sv
// Max-min distance slot allocator, top level. An arrive beat is answered after a full
// scan of the ring; the next beat is taken once that answer is loaded into the output
// register. The occupancy bits sit in a ring of cells that rotates one slot per cycle
// during the scan past a single gap scanner, so every arrive scans the whole ring. A
// leave with a live reference passes the read, free and record states, any other leave
// only the record state. The event table has no clearing pass: every event number is
// written in order, and a reference at or beyond the current event number reads as empty.
// Depends on mmdsa_pkg, mmdsa_cell and mmdsa_scan.
module max_min_distance_slot_allocator
	import mmdsa_pkg::*;
#(
	parameter int MAX_CHAIRS = 64,
	parameter int MAX_EVENTS = 1024
)
(
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [CFG_W-1:0]                    cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                action,
	input  logic [$clog2(MAX_EVENTS)-1:0]       event_ref,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [$clog2(MAX_CHAIRS+1)-1:0]     chair,
	output logic                                full_res
);

	localparam int CW   = $clog2(MAX_CHAIRS + 1);
	localparam int EW   = $clog2(MAX_EVENTS);
	localparam int CNTW = $clog2(MAX_EVENTS + 1);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SCAN    = 3'd1;
	localparam logic [2:0] S_FIN     = 3'd2;
	localparam logic [2:0] S_LV_RD   = 3'd3;
	localparam logic [2:0] S_LV_FREE = 3'd4;
	localparam logic [2:0] S_REC     = 3'd5;
	localparam logic [2:0] S_OUT     = 3'd6;

	logic [2:0]       state_q;
	logic [CFG_W-1:0] num_chairs_q;
	logic [CNTW-1:0]  cnt_q;
	logic [CNTW-1:0]  number_q;
	logic             act_q;
	logic [EW-1:0]    ref_q;
	logic [CW-1:0]    rd_q;
	logic [CW-1:0]    rec_slot_q;
	logic             rec_full_q;
	logic             out_valid_q;
	logic [CW-1:0]    chair_q;
	logic             full_res_q;

	logic [CW-1:0]    evt_mem [MAX_EVENTS];

	logic             in_acc;
	logic [CNTW-1:0]  cnt_nxt;
	logic             ref_ok;
	logic [CW-1:0]    n_eff;
	logic             mem_we;
	logic [EW-1:0]    mem_addr;
	logic [CW-1:0]    mem_wd;
	logic             out_load;

	logic             cell_wr_en;
	logic             cell_wr_val;
	logic [CW-1:0]    cell_wr_slot;
	logic [MAX_CHAIRS-1:0] occ_vec;

	scan_ctrl_t       scan_ctrl;
	logic             last_step;
	logic             pick_ok;
	logic [CW-1:0]    pick_slot;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign cnt_nxt  = (cnt_q < CNTW'(MAX_EVENTS)) ? cnt_q + CNTW'(1) : cnt_q;
	// a live reference names an earlier event; later ones were never written
	assign ref_ok   = (event_ref != '0) && (CNTW'(event_ref) < cnt_nxt);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		if (num_chairs_q == '0) begin
			n_eff = CW'(1);
		end else if (int'(num_chairs_q) > MAX_CHAIRS) begin
			n_eff = CW'(MAX_CHAIRS);
		end else begin
			n_eff = CW'(num_chairs_q);
		end
	end

	always_comb begin
		mem_we   = 1'b0;
		mem_addr = ref_q;
		mem_wd   = '0;
		case (state_q)
			S_LV_FREE: begin
				mem_we = 1'b1;
			end
			S_REC: begin
				mem_we   = (number_q < CNTW'(MAX_EVENTS));
				mem_addr = number_q[EW-1:0];
				mem_wd   = rec_slot_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			evt_mem[mem_addr] <= mem_wd;
		end
		rd_q <= evt_mem[ref_q];
	end

	assign scan_ctrl.start = in_acc && (action == ACT_ARRIVE);
	assign scan_ctrl.step  = (state_q == S_SCAN);

	always_comb begin
		cell_wr_en   = 1'b0;
		cell_wr_val  = 1'b0;
		cell_wr_slot = pick_slot;
		case (state_q)
			S_FIN: begin
				cell_wr_en  = pick_ok;
				cell_wr_val = 1'b1;
			end
			S_LV_FREE: begin
				cell_wr_en   = 1'b1;
				cell_wr_slot = rd_q;
			end
			default: begin
				cell_wr_en = 1'b0;
			end
		endcase
	end

	for (genvar i = 0; i < MAX_CHAIRS; i++) begin : g_cell
		cell_ctrl_t cc;
		assign cc.shift = scan_ctrl.step;
		assign cc.wr    = cell_wr_en && (cell_wr_slot == CW'(i + 1));
		assign cc.val   = cell_wr_val;
		mmdsa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cc),
			.shift_in (occ_vec[(i + 1) % MAX_CHAIRS]),
			.occ      (occ_vec[i])
		);
	end

	mmdsa_scan #(
		.MAX_CHAIRS (MAX_CHAIRS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (scan_ctrl),
		.head      (occ_vec[0]),
		.n_eff     (n_eff),
		.last_step (last_step),
		.pick_ok   (pick_ok),
		.pick_slot (pick_slot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			num_chairs_q <= NUM_CHAIRS_RST;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				num_chairs_q <= cfg_wdata;
			end
			if (in_acc) begin
				cnt_q <= cnt_nxt;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (action == ACT_ARRIVE) begin
							state_q <= S_SCAN;
						end else if (ref_ok) begin
							state_q <= S_LV_RD;
						end else begin
							state_q <= S_REC;
						end
					end
				end
				S_SCAN: begin
					if (last_step) begin
						state_q <= S_FIN;
					end
				end
				S_FIN:     state_q <= S_REC;
				S_LV_RD:   state_q <= S_LV_FREE;
				S_LV_FREE: state_q <= S_REC;
				S_REC: begin
					state_q <= (act_q == ACT_ARRIVE) ? S_OUT : S_IDLE;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			number_q   <= cnt_nxt;
			act_q      <= action;
			ref_q      <= event_ref;
			rec_slot_q <= '0;
			rec_full_q <= 1'b0;
		end
		if (state_q == S_FIN) begin
			rec_slot_q <= pick_ok ? pick_slot : '0;
			rec_full_q <= !pick_ok;
		end
		if (out_load) begin
			chair_q    <= rec_slot_q;
			full_res_q <= rec_full_q;
		end
	end

	assign out_valid = out_valid_q;
	assign chair     = chair_q;
	assign full_res  = full_res_q;

	// a full rotation leaves the number of busy slots unchanged
	a_ring_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |=> ($countones(occ_vec) == $past($countones(occ_vec))))
		else $error("occupancy count changed during scan");

	a_scan_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && last_step) |=> (state_q == S_FIN))
		else $error("scan did not end after last slot");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(MAX_EVENTS))
		else $error("event counter past saturation");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && full_res_q) |-> (chair_q == '0))
		else $error("full result carries a slot");

endmodule

// File: tb/sv/mmdsa_checker.sv
// Scoreboard for the max-min distance slot allocator: mirrors occupancy, event table
// and slot count, predicts every arrive answer and compares each output beat.
// Depends on mmdsa_pkg.
module mmdsa_checker
	import mmdsa_pkg::*;
#(
	parameter int MAX_CHAIRS = 64,
	parameter int MAX_EVENTS = 1024
)
(
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [CFG_W-1:0]                    cfg_wdata,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic                                action,
	input  logic [$clog2(MAX_EVENTS)-1:0]       event_ref,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [$clog2(MAX_CHAIRS+1)-1:0]     chair,
	input  logic                                full_res,
	output int                                  fail_count,
	output int                                  pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOT_W = $clog2(MAX_CHAIRS + 1);
	localparam int unsigned NO_NEIGHBOR = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [SLOT_W-1:0] chair;
		logic              full;
	} seat_answer_t;

	seat_answer_t      answers_due[$];
	logic              taken [1:MAX_CHAIRS];
	logic [SLOT_W-1:0] seat_of_event [0:MAX_EVENTS-1];
	logic [CFG_W-1:0]  chairs_cfg;
	int unsigned       n_events;
	int                n_fail = 0;

	assign fail_count = n_fail;

	task automatic report_mismatch(input string what);
		if (n_fail < 50)
			$display("mismatch at %0t ns: %s", $time, what);
		n_fail++;
	endtask

	// widest gap to the nearest occupied slot, lowest slot on ties, 0 when none free
	function automatic logic [SLOT_W-1:0] pick_seat();
		int unsigned lim;
		int unsigned gap_l [1:MAX_CHAIRS];
		int unsigned gap_r;
		int unsigned gap_min;
		int unsigned best_gap;
		int prev_taken;
		int best;
		if (chairs_cfg == 0)
			lim = 1;
		else if (int'(chairs_cfg) > MAX_CHAIRS)
			lim = MAX_CHAIRS;
		else
			lim = 32'(chairs_cfg);
		prev_taken = 0;
		for (int c = 1; c <= MAX_CHAIRS; c++) begin
			gap_l[c] = (prev_taken == 0) ? NO_NEIGHBOR : c - prev_taken;
			if (taken[c])
				prev_taken = c;
		end
		prev_taken = 0;
		best = 0;
		best_gap = 0;
		// slots above the count still act as neighbors, they are just never picked
		for (int c = MAX_CHAIRS; c >= 1; c--) begin
			gap_r = (prev_taken == 0) ? NO_NEIGHBOR : prev_taken - c;
			gap_min = (gap_l[c] < gap_r) ? gap_l[c] : gap_r;
			if (taken[c]) begin
				prev_taken = c;
			end else if (c <= lim && (best == 0 || gap_min >= best_gap)) begin
				best = c;
				best_gap = gap_min;
			end
		end
		return best[SLOT_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		seat_answer_t      due;
		logic [SLOT_W-1:0] seat;
		if (!arst_n) begin
			chairs_cfg = NUM_CHAIRS_RST;
			n_events = 0;
			for (int c = 1; c <= MAX_CHAIRS; c++)
				taken[c] = 1'b0;
			for (int e = 0; e < MAX_EVENTS; e++)
				seat_of_event[e] = '0;
			answers_due.delete();
			pending_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					report_mismatch($sformatf("output beat with nothing due (chair %0d full %0b)",
						chair, full_res));
				end else begin
					due = answers_due.pop_front();
					if (chair !== due.chair)
						report_mismatch($sformatf("chair %0d, predicted %0d", chair, due.chair));
					if (full_res !== due.full)
						report_mismatch($sformatf("full_res %0b, predicted %0b",
							full_res, due.full));
				end
			end
			if (cfg_we)
				chairs_cfg = cfg_wdata;
			if (in_valid && in_ready) begin
				if (n_events < MAX_EVENTS)
					n_events++;
				if (action == ACT_LEAVE) begin
					if (event_ref != 0 && int'(event_ref) < MAX_EVENTS) begin
						seat = seat_of_event[event_ref];
						if (seat >= 1 && int'(seat) <= MAX_CHAIRS)
							taken[seat] = 1'b0;
						seat_of_event[event_ref] = '0;
					end
				end else begin
					seat = pick_seat();
					if (seat == 0) begin
						due.chair = '0;
						due.full  = 1'b1;
					end else begin
						taken[seat] = 1'b1;
						if (n_events < MAX_EVENTS)
							seat_of_event[n_events] = seat;
						due.chair = seat;
						due.full  = 1'b0;
					end
					answers_due.insert(answers_due.size(), due);
				end
			end
			pending_count <= answers_due.size();
		end
	end

endmodule

// File: tb/sv/tb.sv
// Top of the slot allocator testbench: clock, reset, stimulus, sink pacing and verdict.
// Depends on mmdsa_pkg, max_min_distance_slot_allocator and mmdsa_checker.
module tb;
	import mmdsa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_CHAIRS = 64;
	localparam int MAX_EVENTS = 1024;
	localparam int EV_W = $clog2(MAX_EVENTS);
	localparam int SLOT_W = $clog2(MAX_CHAIRS + 1);
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 600;
	localparam int BEATS_PER_PHASE = 107;

	typedef enum logic [1:0] {
		MODE_SLOW_SINK,
		MODE_SLOW_SOURCE,
		MODE_FREE
	} pace_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CFG_W-1:0]   cfg_wdata = NUM_CHAIRS_RST;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               action = ACT_ARRIVE;
	logic [EV_W-1:0]    event_ref = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [SLOT_W-1:0]  chair;
	logic               full_res;
	int                 fail_count;
	int                 pending_beats;

	pace_mode_t         mode = MODE_SLOW_SINK;
	int                 hold_left = 0;
	logic               held = 1'b0;
	int                 quiet_cycles = 0;
	int                 events_sent = 0;
	logic [EV_W-1:0]    seated_events[$];
	logic [CFG_W-1:0]   counts [12] = '{7'd64, 7'd1, 7'd7, 7'd127, 7'd16, 7'd0,
		7'd45, 7'd3, 7'd64, 7'd2, 7'd100, 7'd33};

	always #4 clk = ~clk;

	max_min_distance_slot_allocator #(
		.MAX_CHAIRS(MAX_CHAIRS),
		.MAX_EVENTS(MAX_EVENTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.event_ref(event_ref),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.chair(chair),
		.full_res(full_res)
	);

	mmdsa_checker #(
		.MAX_CHAIRS(MAX_CHAIRS),
		.MAX_EVENTS(MAX_EVENTS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.event_ref(event_ref),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.chair(chair),
		.full_res(full_res),
		.fail_count(fail_count),
		.pending_count(pending_beats)
	);

	// sink pacing; one long hold once free-running starts, so the block backs up
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (mode == MODE_FREE && !held) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			held <= 1'b1;
		end else begin
			case (mode)
				MODE_SLOW_SINK:   out_ready <= ($urandom_range(0, 99) >= 53);
				MODE_SLOW_SOURCE: out_ready <= ($urandom_range(0, 99) >= 9);
				default:          out_ready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int source_idle_pct();
		case (mode)
			MODE_SLOW_SINK:   return 9;
			MODE_SLOW_SOURCE: return 53;
			default:          return 0;
		endcase
	endfunction

	// called at a rising edge; returns at the edge that takes the beat, valid left high
	task automatic send_beat(input logic act, input logic [EV_W-1:0] evt);
		if ($urandom_range(0, 99) < source_idle_pct()) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < source_idle_pct());
		end
		in_valid <= 1'b1;
		action <= act;
		event_ref <= evt;
		do
			@(posedge clk);
		while (!in_ready);
		if (events_sent < MAX_EVENTS)
			events_sent++;
		if (act == ACT_ARRIVE && events_sent < MAX_EVENTS)
			seated_events.insert(seated_events.size(), events_sent[EV_W-1:0]);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_beats != 0)
			@(posedge clk);
		// a leave may still be in flight with nothing due
		repeat (MAX_CHAIRS + 8)
			@(posedge clk);
	endtask

	task automatic set_chairs(input logic [CFG_W-1:0] count);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= count;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly arrives and leaves of live events, some stray leaves
	task automatic random_beats(input int count);
		int pick;
		int idx;
		logic [EV_W-1:0] evt;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			evt = EV_W'($urandom);
			if (pick < 55) begin
				send_beat(ACT_ARRIVE, evt);
			end else if (pick < 90 && seated_events.size() > 0) begin
				idx = $urandom_range(0, seated_events.size() - 1);
				evt = seated_events[idx];
				seated_events.delete(idx);
				send_beat(ACT_LEAVE, evt);
			end else begin
				send_beat(ACT_LEAVE, evt);
			end
		end
	endtask

	initial begin
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty room, both ends, midpoint tie, stray leaves, full, clamped counts
		send_beat(ACT_ARRIVE, '0);
		send_beat(ACT_ARRIVE, '1);
		send_beat(ACT_ARRIVE, 10'h155);
		send_beat(ACT_LEAVE, '0);
		send_beat(ACT_LEAVE, '1);
		send_beat(ACT_LEAVE, 10'd4);
		send_beat(ACT_LEAVE, 10'd100);
		send_beat(ACT_LEAVE, 10'd2);
		send_beat(ACT_LEAVE, 10'd2);
		send_beat(ACT_ARRIVE, 10'h2AA);
		set_chairs(7'd0);
		send_beat(ACT_ARRIVE, '0);
		send_beat(ACT_ARRIVE, '0);
		send_beat(ACT_LEAVE, 10'd11);
		set_chairs(7'd127);
		send_beat(ACT_ARRIVE, '0);
		send_beat(ACT_ARRIVE, '0);
		set_chairs(7'd2);
		send_beat(ACT_ARRIVE, '0);
		send_beat(ACT_ARRIVE, '0);
		send_beat(ACT_LEAVE, 10'd3);
		send_beat(ACT_ARRIVE, '0);

		for (int p = 0; p < 12; p++) begin
			set_chairs(counts[p]);
			if (p == 4)
				mode <= MODE_SLOW_SOURCE;
			else if (p == 8)
				mode <= MODE_FREE;
			random_beats(BEATS_PER_PHASE);
		end

		drain();
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
